[sv/depth_backproject_transform_top_macros.svh]
// Assertion helpers for the back-projection block; clock and reset are the
// top level's own i_clk and i_rst_n.
`ifndef DEPTH_BACKPROJECT_TRANSFORM_TOP_MACROS_SVH
`define DEPTH_BACKPROJECT_TRANSFORM_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DBT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DBT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dbt_pkg.sv]
package dbt_pkg;

    // field widths
    localparam int ROW_W   = 12;
    localparam int COL_W   = 12;
    localparam int DEPTH_W = 16;
    localparam int CHAN_W  = 8;
    localparam int WORLD_W = 32;

    // register widths
    localparam int PP_W    = 16;
    localparam int FINV_W  = 32;
    localparam int COEF_W  = 20;
    localparam int ROT_W   = 3 * COEF_W;
    localparam int TOFF_W  = 21;
    localparam int TRANS_W = 3 * TOFF_W;
    localparam int CFG_W   = TRANS_W;
    localparam int CFG_IDX_W = 3;

    // frame defaults
    localparam int MAX_ROWS_DEF = 4096;
    localparam int MAX_COLS_DEF = 4096;

    // depth / 500 in Q16.16: (d * 16384 + 62) / 125 by reciprocal, exact below 2^30
    localparam int                 ZNUM_W    = 30;
    localparam int                 ZRECIP_W  = 31;
    localparam int                 ZSHIFT    = 37;
    localparam logic [ZRECIP_W-1:0] ZRECIP   = 31'd1099511628;
    localparam logic [ZNUM_W-1:0]   ZBIAS    = 30'd62;
    localparam int                 Z_W       = 24;

    // datapath widths
    localparam int DQ_W    = 18;
    localparam int MAG_W   = 16;
    localparam int T_W     = MAG_W + Z_W;
    localparam int PP2_W   = T_W + 16;
    localparam int LSUM_W  = T_W + FINV_W;
    localparam int LAT_W   = 37;
    localparam int PROD_W  = COEF_W + LAT_W;
    localparam int ACC_W   = 60;

    // pipeline depth from accepted request to result strobe
    localparam int LATENCY = 8;

    localparam logic [ROT_W-1:0] ROT0_RST = ROT_W'(1) << 18;
    localparam logic [ROT_W-1:0] ROT1_RST = ROT_W'(1) << 38;
    localparam logic [ROT_W-1:0] ROT2_RST = ROT_W'(1) << 58;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRINCIPAL_X  = 3'd0,
        CFG_PRINCIPAL_Y  = 3'd1,
        CFG_FOCAL_X_INV  = 3'd2,
        CFG_FOCAL_Y_INV  = 3'd3,
        CFG_ROTATION_R0  = 3'd4,
        CFG_ROTATION_R1  = 3'd5,
        CFG_ROTATION_R2  = 3'd6,
        CFG_TRANSLATION  = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_colour;

endpackage

[sv/depth_backproject_transform_top.sv]
// Depth back-projection: one depth pixel in, at most one coloured world point
// out. A request is taken on every clock edge where start is high and busy is
// low; busy is high only while reset is held, so a pixel may be offered every
// cycle. The result appears on the o_world_* and o_out_* ports for exactly
// one cycle with o_valid high; there is no way to hold it off, so the
// receiver must take it in that cycle. A pixel with zero depth, or lying
// outside MAX_ROWS x MAX_COLS, gives no strobe at all. Throughput is one
// pixel per clock through the eight register stages: depth scaling, lateral
// magnitude product, focal-inverse partial products, lateral rounding,
// rotation products, accumulation, magnitude and finally rounding with
// saturation. The eight configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_wdata and must only change while no
// request is in flight; the rotation resets to the identity, everything
// else to zero.
`include "depth_backproject_transform_top_macros.svh"

module depth_backproject_transform_top #(
    parameter int MAX_ROWS = dbt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = dbt_pkg::MAX_COLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dbt_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               start,
    output logic                               busy,
    input  logic [dbt_pkg::ROW_W-1:0]          i_row_index,
    input  logic [dbt_pkg::COL_W-1:0]          i_col_index,
    input  logic [dbt_pkg::DEPTH_W-1:0]        i_depth_raw,
    input  logic [dbt_pkg::CHAN_W-1:0]         i_blue,
    input  logic [dbt_pkg::CHAN_W-1:0]         i_green,
    input  logic [dbt_pkg::CHAN_W-1:0]         i_red,
    output logic                               o_valid,
    output logic signed [dbt_pkg::WORLD_W-1:0] o_world_x,
    output logic signed [dbt_pkg::WORLD_W-1:0] o_world_y,
    output logic signed [dbt_pkg::WORLD_W-1:0] o_world_z,
    output logic [dbt_pkg::CHAN_W-1:0]         o_out_blue,
    output logic [dbt_pkg::CHAN_W-1:0]         o_out_green,
    output logic [dbt_pkg::CHAN_W-1:0]         o_out_red
);
    import dbt_pkg::*;

    // frame limits, wide enough to hold the full parameter range
    localparam int               LIM_W   = 17;
    localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_ROWS);
    localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_COLS);

    localparam logic [LSUM_W-1:0] LAT_RND = LSUM_W'(1) << 35;
    localparam logic [ACC_W:0]    OUT_RND = (ACC_W + 1)'(1) << 17;
    localparam int                Q_W     = ACC_W + 1 - 18;
    localparam logic [Q_W-1:0]    POS_MAX = Q_W'(32'h7FFF_FFFF);
    localparam logic [Q_W-1:0]    NEG_MAX = Q_W'(32'h8000_0000);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PP_W-1:0]    r_px;
    logic [PP_W-1:0]    r_py;
    logic [FINV_W-1:0]  r_finv [2];
    logic [ROT_W-1:0]   r_rot  [3];
    logic [TRANS_W-1:0] r_trans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px      <= '0;
            r_py      <= '0;
            r_finv[0] <= '0;
            r_finv[1] <= '0;
            r_rot[0]  <= ROT0_RST;
            r_rot[1]  <= ROT1_RST;
            r_rot[2]  <= ROT2_RST;
            r_trans   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PRINCIPAL_X: r_px      <= i_cfg_wdata[PP_W-1:0];
                CFG_PRINCIPAL_Y: r_py      <= i_cfg_wdata[PP_W-1:0];
                CFG_FOCAL_X_INV: r_finv[0] <= i_cfg_wdata[FINV_W-1:0];
                CFG_FOCAL_Y_INV: r_finv[1] <= i_cfg_wdata[FINV_W-1:0];
                CFG_ROTATION_R0: r_rot[0]  <= i_cfg_wdata[ROT_W-1:0];
                CFG_ROTATION_R1: r_rot[1]  <= i_cfg_wdata[ROT_W-1:0];
                CFG_ROTATION_R2: r_rot[2]  <= i_cfg_wdata[ROT_W-1:0];
                CFG_TRANSLATION: r_trans   <= i_cfg_wdata[TRANS_W-1:0];
                default:         r_px      <= r_px;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request acceptance: take a request whenever start is high outside
    // reset; keep it only if the depth is non-zero and the pixel in frame.
    // ------------------------------------------------------------------
    logic    w_take;
    logic    w_keep;
    logic    w_kept;
    t_colour w_in_col;

    assign busy     = !i_rst_n;
    assign w_take   = start && !busy;
    assign w_keep   = (i_depth_raw != '0)
                   && ({(LIM_W - ROW_W)'(0), i_row_index} < ROW_LIM)
                   && ({(LIM_W - COL_W)'(0), i_col_index} < COL_LIM);
    assign w_kept   = w_take && w_keep;
    assign w_in_col = '{blue: i_blue, green: i_green, red: i_red};

    // valid bits travel alongside the data; no stall exists
    logic [LATENCY:1] r_vld;
    logic [LATENCY:1] n_vld;

    assign n_vld = {r_vld[LATENCY-1:1], w_kept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // colour rides a plain shift line alongside the point
    t_colour r_col [LATENCY-1];

    always_ff @(posedge i_clk) begin
        r_col[0] <= w_in_col;
        for (int s = 1; s < LATENCY - 1; s++) begin
            r_col[s] <= r_col[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: z = depth / 500 in Q16.16, rounded half up, via reciprocal
    // multiply; offsets from the principal point in Q12.4.
    // ------------------------------------------------------------------
    logic [ZNUM_W-1:0]            w_znum;
    logic [ZNUM_W+ZRECIP_W-1:0]   w_zprod;
    logic [Z_W-1:0]               r_z1;
    logic signed [DQ_W-1:0]       r_dq1 [2];

    assign w_znum  = {i_depth_raw, (ZNUM_W - DEPTH_W)'(0)} + ZBIAS;
    assign w_zprod = (ZNUM_W + ZRECIP_W)'(w_znum) * (ZNUM_W + ZRECIP_W)'(ZRECIP);

    always_ff @(posedge i_clk) begin
        r_z1     <= w_zprod[ZSHIFT +: Z_W];
        r_dq1[0] <= $signed({2'b00, i_row_index, 4'b0000}) - $signed({2'b00, r_px});
        r_dq1[1] <= $signed({2'b00, i_col_index, 4'b0000}) - $signed({2'b00, r_py});
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude of each offset times z; remember the sign.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] w_mag [2];
    logic [T_W-1:0]   r_t2  [2];
    logic             r_neg2 [2];
    logic [Z_W-1:0]   r_z2;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_mag[a] = r_dq1[a][DQ_W-1] ? MAG_W'(-r_dq1[a]) : MAG_W'(r_dq1[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            r_t2[a]   <= T_W'(w_mag[a]) * T_W'(r_z1);
            r_neg2[a] <= r_dq1[a][DQ_W-1];
        end
        r_z2 <= r_z1;
    end

    // ------------------------------------------------------------------
    // Stage 3: split the focal inverse into halves to keep each multiplier
    // near 40x16; hold both partial products.
    // ------------------------------------------------------------------
    logic [PP2_W-1:0] r_ph3 [2];
    logic [PP2_W-1:0] r_pl3 [2];
    logic             r_neg3 [2];
    logic [Z_W-1:0]   r_z3;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 2; a++) begin
            r_ph3[a]  <= PP2_W'(r_t2[a]) * PP2_W'(r_finv[a][FINV_W-1:16]);
            r_pl3[a]  <= PP2_W'(r_t2[a]) * PP2_W'(r_finv[a][15:0]);
            r_neg3[a] <= r_neg2[a];
        end
        r_z3 <= r_z2;
    end

    // ------------------------------------------------------------------
    // Stage 4: recombine, round half away from zero down to Q16.16 and put
    // the sign back. Full width, no saturation at this point.
    // ------------------------------------------------------------------
    logic [LSUM_W-1:0]       w_lsum [2];
    logic signed [LAT_W-1:0] w_lat  [2];
    logic signed [LAT_W-1:0] r_c4   [3];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_lsum[a] = {r_ph3[a], 16'h0000} + LSUM_W'(r_pl3[a]) + LAT_RND;
            w_lat[a]  = r_neg3[a] ? -$signed({1'b0, w_lsum[a][LSUM_W-1:36]})
                                  :  $signed({1'b0, w_lsum[a][LSUM_W-1:36]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_c4[0] <= w_lat[0];
        r_c4[1] <= w_lat[1];
        r_c4[2] <= $signed({(LAT_W - Z_W)'(0), r_z3});
    end

    // ------------------------------------------------------------------
    // Stage 5: nine rotation products, coefficient Q2.18 by Q16.16.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_p5 [3][3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_p5[k][j] <= PROD_W'($signed(r_rot[k][COEF_W*j +: COEF_W]))
                            * PROD_W'(r_c4[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sum each row and add the translation lifted to Q.34.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] r_acc6 [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_acc6[k] <= ACC_W'(r_p5[k][0]) + ACC_W'(r_p5[k][1]) + ACC_W'(r_p5[k][2])
                       + ACC_W'($signed({r_trans[TOFF_W*k +: TOFF_W], 24'h000000}));
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: split each sum into sign and magnitude.
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] r_m7   [3];
    logic             r_neg7 [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_m7[k]   <= r_acc6[k][ACC_W-1] ? ACC_W'(-r_acc6[k]) : ACC_W'(r_acc6[k]);
            r_neg7[k] <= r_acc6[k][ACC_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: round half away from zero to Q16.16, clamp to the signed
    // 32-bit range and drive the result registers.
    // ------------------------------------------------------------------
    logic [ACC_W:0]          w_rsum [3];
    logic [Q_W-1:0]          w_q    [3];
    logic [Q_W-1:0]          w_qs   [3];
    logic [WORLD_W-1:0]      w_res  [3];
    logic signed [WORLD_W-1:0] r_world [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rsum[k] = {1'b0, r_m7[k]} + OUT_RND;
            w_q[k]    = w_rsum[k][ACC_W:18];
            if (r_neg7[k]) begin
                w_qs[k]  = (w_q[k] > NEG_MAX) ? NEG_MAX : w_q[k];
                w_res[k] = WORLD_W'(-w_qs[k]);
            end else begin
                w_qs[k]  = (w_q[k] > POS_MAX) ? POS_MAX : w_q[k];
                w_res[k] = WORLD_W'(w_qs[k]);
            end
        end
    end

    t_colour r_ocol;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_world[k] <= $signed(w_res[k]);
        end
        r_ocol <= r_col[LATENCY-2];
    end

    assign o_valid     = r_vld[LATENCY];
    assign o_world_x   = r_world[0];
    assign o_world_y   = r_world[1];
    assign o_world_z   = r_world[2];
    assign o_out_blue  = r_ocol.blue;
    assign o_out_green = r_ocol.green;
    assign o_out_red   = r_ocol.red;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a strobe always traces back to a kept request that has passed through the whole pipeline
    `DBT_ASSERT_IMP(a_strobe_origin, o_valid, $past(w_kept, LATENCY), "result without kept request")
    // colour must stay aligned with its point through the whole pipeline
    `DBT_ASSERT_IMP(a_colour_align, o_valid, r_ocol == $past(w_in_col, LATENCY), "colour out of step")
    // any non-zero depth yields a non-zero z after scaling
    `DBT_ASSERT_NXT(a_depth_scale, w_kept, r_z1 != '0, "depth scaling lost a non-zero depth")

endmodule

[test/tb_depth_backproject_transform_top.sv]
module tb_depth_backproject_transform_top;
    import dbt_pkg::*;

    // The default frame size is used, so a 12-bit row or column is always in frame.
    localparam int N_ROWS = MAX_ROWS_DEF;
    localparam int N_COLS = MAX_COLS_DEF;

    // 500 depth units per metre.
    localparam longint DEPTH_UNITS = 500;

    // This ceiling is well above the length of the whole run.
    localparam int CLOCK_LIMIT = 100000;

    // Cycles to wait after the last point, so that no request is still in flight.
    localparam int SETTLE_CYCLES = LATENCY + 4;

    // Q2.18 rotation coefficients.
    localparam logic [COEF_W-1:0] COEF_ONE  = 20'h40000;
    localparam logic [COEF_W-1:0] COEF_MAXP = 20'h7FFFF;
    localparam logic [COEF_W-1:0] COEF_MAXN = 20'h80000;

    // Q11.10 translation offsets.
    localparam logic [TOFF_W-1:0] TOFF_MAXP = 21'h0FFFFF;
    localparam logic [TOFF_W-1:0] TOFF_MAXN = 21'h100000;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [DEPTH_W-1:0] depth;
        t_colour            colour;
    } t_pixel;

    typedef struct packed {
        logic signed [WORLD_W-1:0] x;
        logic signed [WORLD_W-1:0] y;
        logic signed [WORLD_W-1:0] z;
        t_colour                   colour;
    } t_point;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata  = '0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [ROW_W-1:0]     i_row_index  = '0;
    logic [COL_W-1:0]     i_col_index  = '0;
    logic [DEPTH_W-1:0]   i_depth_raw  = '0;
    logic [CHAN_W-1:0]    i_blue       = '0;
    logic [CHAN_W-1:0]    i_green      = '0;
    logic [CHAN_W-1:0]    i_red        = '0;
    logic                 o_valid;
    logic signed [WORLD_W-1:0] o_world_x;
    logic signed [WORLD_W-1:0] o_world_y;
    logic signed [WORLD_W-1:0] o_world_z;
    logic [CHAN_W-1:0]    o_out_blue;
    logic [CHAN_W-1:0]    o_out_green;
    logic [CHAN_W-1:0]    o_out_red;

    // Our copy of the configuration, starting from the reset values.
    logic [PP_W-1:0]    cam_px    = '0;
    logic [PP_W-1:0]    cam_py    = '0;
    logic [FINV_W-1:0]  cam_fxi   = '0;
    logic [FINV_W-1:0]  cam_fyi   = '0;
    logic [ROT_W-1:0]   cam_rot [3] = '{ROT0_RST, ROT1_RST, ROT2_RST};
    logic [TRANS_W-1:0] cam_trans = '0;

    t_pixel pixel_queue [$];   // pixels waiting to be offered
    t_point point_queue [$];   // world points still owed by the block
    t_pixel offered;
    t_point predicted;
    t_point seen;
    t_point wanted;
    bit     steady_flow = 1'b0;
    int     errors      = 0;
    int     cycle_count = 0;

    depth_backproject_transform_top #(
        .MAX_ROWS(N_ROWS),
        .MAX_COLS(N_COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_depth_raw (i_depth_raw),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_valid     (o_valid),
        .o_world_x   (o_world_x),
        .o_world_y   (o_world_y),
        .o_world_z   (o_world_z),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Sign-extend the low w bits of v.
    function automatic longint sign_extend(input bit [63:0] v, input int unsigned w);
        longint s;
        s = v << (64 - w);
        return s >>> (64 - w);
    endfunction

    // Q12.4 offset times Q16.16 depth times Q0.32 inverse focal length, back to
    // Q16.16. The inverse is split into halves so that nothing overflows 64 bits;
    // rounding is half away from zero on the magnitude.
    function automatic longint lateral_offset(input longint dq, input bit [63:0] z,
                                              input bit [FINV_W-1:0] inv);
        bit [63:0] mag;
        bit [63:0] t;
        bit [63:0] p;
        bit [63:0] r;
        mag = (dq < 0) ? -dq : dq;
        t   = mag * z;
        p   = t * inv[31:16] + ((t * inv[15:0]) >> 16);
        r   = (p + (64'd1 << 19)) >> 20;
        return (dq < 0) ? -longint'(r) : longint'(r);
    endfunction

    // One rotation row dotted with the camera point, plus the offset for this
    // axis, rounded half away from zero and clamped to 32 signed bits.
    function automatic logic signed [WORLD_W-1:0] world_coord(input bit [ROT_W-1:0] coefs,
                                                              input longint c0,
                                                              input longint c1,
                                                              input longint c2,
                                                              input int axis);
        longint    acc;
        bit [63:0] mag;
        bit [63:0] q;
        acc = sign_extend(coefs, COEF_W) * c0
            + sign_extend(coefs >> COEF_W, COEF_W) * c1
            + sign_extend(coefs >> (2 * COEF_W), COEF_W) * c2;
        acc += sign_extend(cam_trans >> (TOFF_W * axis), TOFF_W) * (longint'(1) << 24);
        mag = (acc < 0) ? -acc : acc;
        q   = (mag + (64'd1 << 17)) >> 18;
        if (acc < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return WORLD_W'(-longint'(q));
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return WORLD_W'(q);
    endfunction

    // Work out the world point a pixel should give; zero depth and pixels off
    // the frame give none.
    function automatic bit backproject(input t_pixel pix, output t_point pt);
        bit [63:0] z;
        longint    cx;
        longint    cy;
        pt = '0;
        if (pix.depth == 0 || pix.row >= N_ROWS || pix.col >= N_COLS) return 1'b0;
        z  = (64'(pix.depth) * 65536 + DEPTH_UNITS / 2) / DEPTH_UNITS;
        cx = lateral_offset(longint'(pix.row) * 16 - longint'(cam_px), z, cam_fxi);
        cy = lateral_offset(longint'(pix.col) * 16 - longint'(cam_py), z, cam_fyi);
        pt.x      = world_coord(cam_rot[0], cx, cy, longint'(z), 0);
        pt.y      = world_coord(cam_rot[1], cx, cy, longint'(z), 1);
        pt.z      = world_coord(cam_rot[2], cx, cy, longint'(z), 2);
        pt.colour = pix.colour;
        return 1'b1;
    endfunction

    function automatic t_pixel make_pixel(input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col,
                                          input logic [DEPTH_W-1:0] depth,
                                          input logic [CHAN_W-1:0] b,
                                          input logic [CHAN_W-1:0] g,
                                          input logic [CHAN_W-1:0] r);
        t_pixel p;
        p.row          = row;
        p.col          = col;
        p.depth        = depth;
        p.colour.blue  = b;
        p.colour.green = g;
        p.colour.red   = r;
        return p;
    endfunction

    // Mostly valid depths with random content; some zero depths, some very
    // near, some at full range, and the frame edges now and then.
    function automatic t_pixel random_pixel();
        t_pixel      p;
        int unsigned sel;
        p.row    = ROW_W'($urandom);
        p.col    = COL_W'($urandom);
        p.colour = t_colour'((3 * CHAN_W)'($urandom));
        sel      = $urandom_range(0, 99);
        if (sel < 10)      p.depth = '0;
        else if (sel < 20) p.depth = DEPTH_W'($urandom_range(1, 15));
        else if (sel < 25) p.depth = '1;
        else               p.depth = DEPTH_W'($urandom_range(1, 65535));
        if ($urandom_range(0, 19) == 0) p.row = {ROW_W{$urandom_range(0, 1) == 1}};
        if ($urandom_range(0, 19) == 0) p.col = {COL_W{$urandom_range(0, 1) == 1}};
        return p;
    endfunction

    // Zero, anything at all, or the reciprocal of a plausible focal length.
    function automatic logic [FINV_W-1:0] random_focal_inverse();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return $urandom;
            default: return 32'hFFFF_FFFF / $urandom_range(100, 3000);
        endcase
    endfunction

    // Append one pixel to the pending list.
    task automatic queue_pixel(input t_pixel pix);
        pixel_queue = {pixel_queue, pix};
    endtask

    // Write one register, then mirror it in our copy once the write edge is past.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_PRINCIPAL_X: cam_px     = value[PP_W-1:0];
            CFG_PRINCIPAL_Y: cam_py     = value[PP_W-1:0];
            CFG_FOCAL_X_INV: cam_fxi    = value[FINV_W-1:0];
            CFG_FOCAL_Y_INV: cam_fyi    = value[FINV_W-1:0];
            CFG_ROTATION_R0: cam_rot[0] = value[ROT_W-1:0];
            CFG_ROTATION_R1: cam_rot[1] = value[ROT_W-1:0];
            CFG_ROTATION_R2: cam_rot[2] = value[ROT_W-1:0];
            CFG_TRANSLATION: cam_trans  = value[TRANS_W-1:0];
            default: ;
        endcase
    endtask

    // Write all eight registers; with noisy set, fill the unused upper data
    // bits with junk, which the block must drop.
    task automatic apply_camera(input logic [PP_W-1:0] px, input logic [PP_W-1:0] py,
                                input logic [FINV_W-1:0] fxi, input logic [FINV_W-1:0] fyi,
                                input logic [ROT_W-1:0] r0, input logic [ROT_W-1:0] r1,
                                input logic [ROT_W-1:0] r2, input logic [TRANS_W-1:0] tr,
                                input bit noisy);
        logic [CFG_W-1:0] junk;
        junk = noisy ? CFG_W'({$urandom, $urandom}) : '0;
        write_reg(CFG_PRINCIPAL_X, {junk[CFG_W-1:PP_W], px});
        write_reg(CFG_PRINCIPAL_Y, {junk[CFG_W-1:PP_W], py});
        write_reg(CFG_FOCAL_X_INV, {junk[CFG_W-1:FINV_W], fxi});
        write_reg(CFG_FOCAL_Y_INV, {junk[CFG_W-1:FINV_W], fyi});
        write_reg(CFG_ROTATION_R0, {junk[CFG_W-1:ROT_W], r0});
        write_reg(CFG_ROTATION_R1, {junk[CFG_W-1:ROT_W], r1});
        write_reg(CFG_ROTATION_R2, {junk[CFG_W-1:ROT_W], r2});
        write_reg(CFG_TRANSLATION, tr);
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) queue_pixel(random_pixel());
    endtask

    // Wait on the falling edge, where everything has settled, until every
    // pixel has gone in and every point has come out; then let the pipeline
    // empty of requests that give no point.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (start || pixel_queue.size() != 0 || point_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: a request is taken at an edge with start high and busy low.
    // Predict its point at that edge, then offer the next pixel or idle.
    // Hold start high across back-to-back requests; never drop and raise it
    // in the same step.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                if (backproject(offered, predicted)) point_queue = {point_queue, predicted};
            end
            if (!start || !busy) begin
                if (pixel_queue.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 33)) begin
                    offered      = pixel_queue.pop_front();
                    i_row_index <= offered.row;
                    i_col_index <= offered.col;
                    i_depth_raw <= offered.depth;
                    i_blue      <= offered.colour.blue;
                    i_green     <= offered.colour.green;
                    i_red       <= offered.colour.red;
                    start       <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: the strobe lasts one cycle and cannot be held off, so take
    // every point at the edge that ends its cycle and match it against the
    // oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen = {o_world_x, o_world_y, o_world_z, o_out_blue, o_out_green, o_out_red};
            if (point_queue.size() == 0) begin
                $display("%0t: unexpected point x %0d y %0d z %0d bgr %h", $time,
                         seen.x, seen.y, seen.z, seen.colour);
                errors++;
            end else begin
                wanted = point_queue.pop_front();
                if (seen !== wanted) begin
                    $display({"%0t: point mismatch: expected x %0d y %0d z %0d bgr %h,",
                              " actual x %0d y %0d z %0d bgr %h"},
                             $time, wanted.x, wanted.y, wanted.z, wanted.colour,
                             seen.x, seen.y, seen.z, seen.colour);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a point that never comes, or a stuck busy, ends the run here.
    initial begin
        while (cycle_count < CLOCK_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: identity rotation, zero focal inverses, so the
        // lateral terms vanish and the point is just the scaled depth. Drop
        // zero depths; hit the depth, frame and colour extremes.
        queue_pixel(make_pixel(0, 0, 0, 8'h00, 8'h00, 8'h00));
        queue_pixel(make_pixel(0, 0, 1, 8'h00, 8'h00, 8'h00));
        queue_pixel(make_pixel(4095, 4095, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        queue_pixel(make_pixel(4095, 0, 500, 8'h5A, 8'hA5, 8'h3C));
        queue_pixel(make_pixel(123, 456, 0, 8'hFF, 8'h00, 8'hFF));
        queue_random(100);
        wait_idle();

        // A plausible camera with a small offset; run this stretch with no
        // idling at all. The pixel at the principal point has no lateral part.
        apply_camera(16'd5120, 16'd3840, 32'd8180803, 32'd8180803,
                     {20'd0, 20'd0, COEF_ONE}, {20'd0, COEF_ONE, 20'd0},
                     {COEF_ONE, 20'd0, 20'd0}, {21'h000400, 21'h1FFE00, 21'h000000}, 1'b0);
        steady_flow = 1'b1;
        queue_pixel(make_pixel(320, 240, 1000, 8'h11, 8'h22, 8'h33));
        queue_pixel(make_pixel(0, 0, 16'hFFFF, 8'h00, 8'hFF, 8'h00));
        queue_pixel(make_pixel(4095, 4095, 16'hFFFF, 8'hFF, 8'h00, 8'hFF));
        queue_pixel(make_pixel(0, 4095, 250, 8'h80, 8'h7F, 8'h01));
        queue_pixel(make_pixel(4095, 0, 1, 8'h01, 8'h80, 8'hFE));
        queue_random(200);
        wait_idle();
        steady_flow = 1'b0;

        // Extreme principal points and inverses with the most negative
        // coefficients and offsets: drives the sums far past the Q16.16 range.
        apply_camera(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     {3{COEF_MAXN}}, {3{COEF_MAXN}}, {3{COEF_MAXN}},
                     {3{TOFF_MAXN}}, 1'b0);
        queue_pixel(make_pixel(0, 0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        queue_pixel(make_pixel(4095, 4095, 16'hFFFF, 8'h00, 8'h00, 8'h00));
        queue_pixel(make_pixel(4095, 4095, 1, 8'hC3, 8'h3C, 8'h99));
        queue_pixel(make_pixel(0, 4095, 0, 8'h00, 8'h00, 8'h00));
        queue_random(200);
        wait_idle();

        // Most positive coefficients on two rows, most negative on the third:
        // saturate upward and downward in the same point.
        apply_camera(16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     {3{COEF_MAXP}}, {3{COEF_MAXP}}, {3{COEF_MAXN}},
                     {3{TOFF_MAXP}}, 1'b0);
        queue_pixel(make_pixel(4095, 4095, 16'hFFFF, 8'h12, 8'h34, 8'h56));
        queue_pixel(make_pixel(0, 0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        queue_pixel(make_pixel(0, 0, 1, 8'h00, 8'h00, 8'h00));
        queue_pixel(make_pixel(2048, 2048, 32768, 8'hAA, 8'h55, 8'hAA));
        queue_random(150);
        wait_idle();

        // Random cameras, with junk in the unused upper write-data bits.
        for (int k = 0; k < 4; k++) begin
            apply_camera(PP_W'($urandom), PP_W'($urandom),
                         random_focal_inverse(), random_focal_inverse(),
                         ROT_W'({$urandom, $urandom}), ROT_W'({$urandom, $urandom}),
                         ROT_W'({$urandom, $urandom}), TRANS_W'({$urandom, $urandom}),
                         1'b1);
            queue_random(120);
            wait_idle();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
